/* sv/lgs_pkg.sv */
// Shared constants, result types and a helper function for the Life generation stencil.
package lgs_pkg;

    // Grid limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;
    localparam int RESET_DIM  = 1024;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int LIVE_W     = 21;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WINDOW_W   = 9;
    localparam int NBR_W      = 4;

    localparam logic [LIVE_W-1:0] LIVE_LIMIT = LIVE_W'(1048576);

    // Life rule counts
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Result queue geometry (depth must be a power of two)
    localparam int SLOTS    = 3;
    localparam int SLOT_W   = $clog2(SLOTS + 1);
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_LVL_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               alive;
        logic [LIVE_W-1:0]  live;
        logic               done;
    } result_t;

    // All results caused by one input cell, packed from slot 0 upward
    typedef struct packed {
        result_t [SLOTS-1:0] res;
        logic [SLOT_W-1:0]   count;
    } bundle_t;

    // Clamp a grid dimension to its legal range and return the last index
    function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                   input int hi);
        logic [DIM_W-1:0] c;
        if (v < DIM_W'(MIN_DIM)) begin
            c = DIM_W'(MIN_DIM);
        end else if (v > DIM_W'(hi)) begin
            c = DIM_W'(hi);
        end else begin
            c = v;
        end
        return COORD_W'(c - DIM_W'(1));
    endfunction

endpackage

/* sv/lgs_if.sv */
// Valid/ready channel interfaces for cell input and result output.
interface lgs_cell_if;
    logic valid;
    logic ready;
    logic cell_in;

    modport source (output valid, output cell_in, input ready);
    modport sink (input valid, input cell_in, output ready);
endinterface

interface lgs_result_if
    import lgs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cell_column;
    logic [COORD_W-1:0] cell_row;
    logic               next_alive;
    logic [LIVE_W-1:0]  live_total;
    logic               generation_done;

    modport source (output valid, output cell_column, output cell_row, output next_alive,
                    output live_total, output generation_done, input ready);
    modport sink (input valid, input cell_column, input cell_row, input next_alive,
                  input live_total, input generation_done, output ready);
endinterface

/* sv/life_generation_stencil.sv */
// Life generation stencil top level: line buffer memory, 3x3 window and rule evaluation.
// Computes one B3/S23 generation over a raster stream of cells, one cell accepted per
// clock. Each cell causes zero to three results (none on row 1, two at row ends and on
// the last row, three at the last cell); results leave one per transfer, so the input
// keeps one cell per clock where each cell yields one result and slows to the output
// rate elsewhere, governed by a four-bundle result queue. A cell is registered with its
// line buffer read, the window and rule act on those registers, and the results are
// queued. Both line buffers share one 2-bit-wide, MAX_WIDTH-deep memory that is read and
// written back once per cell; it needs no clearing pass after reset. Write grid_width
// and grid_height only while the block is idle; out-of-range values are clamped to 3..1024.
module life_generation_stencil
    import lgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data,
    lgs_cell_if.sink              cell_chan,
    lgs_result_if.source          result_chan
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               cur;
        logic               row_end;
        logic               last_row;
        logic               gen_end;
    } stage_t;

    // Line buffer word: bit 0 row above, bit 1 middle row
    logic [1:0]          line_mem [MAX_WIDTH];
    logic [1:0]          rd_word_reg;

    logic [COORD_W-1:0]  width_last_reg;
    logic [COORD_W-1:0]  height_last_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [COORD_W-1:0]  row_reg;
    logic                s2_valid_reg;
    stage_t              s2_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [LIVE_W-1:0]   live_reg;

    logic                in_xfer;
    logic                row_end;
    logic                last_row;
    logic                gen_end;
    logic [WINDOW_W-1:0] win_next;
    logic [NBR_W-1:0]    nbr_count;
    logic                self_alive;
    logic                alive;
    logic                interior;
    logic                live_inc;
    logic [LIVE_W-1:0]   live_next;
    bundle_t             bundle;
    logic                push;
    logic [Q_LVL_W-1:0]  q_level;

    function automatic logic [NBR_W-1:0] count_neighbors(input logic [WINDOW_W-1:0] w);
        logic [NBR_W-1:0] n;
        n = '0;
        for (int i = 0; i < WINDOW_W; i++) begin
            if (i != 4) begin
                n = n + NBR_W'(w[i]);
            end
        end
        return n;
    endfunction

    function automatic result_t make_result(input logic [COORD_W-1:0] column,
                                            input logic [COORD_W-1:0] row,
                                            input logic               a,
                                            input logic [LIVE_W-1:0]  live,
                                            input logic               done);
        result_t r;
        r.column = column;
        r.row    = row;
        r.alive  = a;
        r.live   = live;
        r.done   = done;
        return r;
    endfunction

    // Hold configuration as clamped last indexes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_last_reg  <= dim_last(DIM_W'(RESET_DIM), MAX_WIDTH);
            height_last_reg <= dim_last(DIM_W'(RESET_DIM), MAX_HEIGHT);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  width_last_reg  <= dim_last(cfg_data, MAX_WIDTH);
                CFG_GRID_HEIGHT: height_last_reg <= dim_last(cfg_data, MAX_HEIGHT);
            endcase
        end
    end

    // Accept a cell while the queue has room for it and the cell in flight
    assign cell_chan.ready = ((Q_LVL_W+1)'(q_level) + (Q_LVL_W+1)'(s2_valid_reg))
                             < (Q_LVL_W+1)'(Q_DEPTH);
    assign in_xfer  = cell_chan.valid && cell_chan.ready;
    assign row_end  = (col_reg >= width_last_reg);
    assign last_row = (row_reg >= height_last_reg) && (row_reg != '0);
    assign gen_end  = row_end && last_row;

    // Advance raster position and load the rule stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= in_xfer;
            if (in_xfer) begin
                if (gen_end) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (row_end) begin
                    col_reg <= '0;
                    row_reg <= row_reg + COORD_W'(1);
                end else begin
                    col_reg <= col_reg + COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_xfer) begin
            s2_reg.x        <= col_reg;
            s2_reg.y        <= row_reg;
            s2_reg.cur      <= cell_chan.cell_in;
            s2_reg.row_end  <= row_end;
            s2_reg.last_row <= last_row;
            s2_reg.gen_end  <= gen_end;
        end
    end

    // Read the line buffers on transfer, write back shifted rows in the next cycle
    always_ff @(posedge clk) begin
        if (in_xfer) begin
            rd_word_reg <= line_mem[col_reg[ADDR_W-1:0]];
        end
        if (s2_valid_reg) begin
            line_mem[s2_reg.x[ADDR_W-1:0]] <= {s2_reg.cur, rd_word_reg[1]};
        end
    end

    // Shift the window and apply the rule
    assign win_next   = {s2_reg.cur, rd_word_reg[1], rd_word_reg[0], window_reg[WINDOW_W-1:3]};
    assign self_alive = win_next[4];
    assign nbr_count  = count_neighbors(win_next);
    assign alive      = (nbr_count == BIRTH_COUNT) || ((nbr_count == SURVIVE_COUNT) && self_alive);
    assign interior   = (s2_reg.y >= COORD_W'(2)) && (s2_reg.x >= COORD_W'(2));
    assign live_inc   = interior && alive && (live_reg < LIVE_LIMIT);
    assign live_next  = live_reg + LIVE_W'(live_inc);

    // Pack this cell's results in emission order
    always_comb begin
        logic [SLOT_W-1:0] n;
        n = '0;
        bundle = '0;
        if (s2_reg.y == '0) begin
            bundle.res[n] = make_result(s2_reg.x, '0, 1'b0, live_next, 1'b0);
            n = n + SLOT_W'(1);
        end else begin
            if (s2_reg.y >= COORD_W'(2)) begin
                if (s2_reg.x == COORD_W'(1)) begin
                    bundle.res[n] = make_result('0, s2_reg.y - COORD_W'(1), 1'b0,
                                                live_next, 1'b0);
                    n = n + SLOT_W'(1);
                end else if (interior) begin
                    bundle.res[n] = make_result(s2_reg.x - COORD_W'(1),
                                                s2_reg.y - COORD_W'(1), alive,
                                                live_next, 1'b0);
                    n = n + SLOT_W'(1);
                end
                if (s2_reg.row_end && (s2_reg.x != '0)) begin
                    bundle.res[n] = make_result(s2_reg.x, s2_reg.y - COORD_W'(1), 1'b0,
                                                live_next, 1'b0);
                    n = n + SLOT_W'(1);
                end
            end
            if (s2_reg.last_row) begin
                bundle.res[n] = make_result(s2_reg.x, s2_reg.y, 1'b0, live_next,
                                            s2_reg.gen_end);
                n = n + SLOT_W'(1);
            end
        end
        bundle.count = n;
    end

    assign push = s2_valid_reg && (bundle.count != '0);

    // Update window and live count, clear both at generation end
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg <= '0;
            live_reg   <= '0;
        end else if (s2_valid_reg) begin
            window_reg <= s2_reg.gen_end ? '0 : win_next;
            live_reg   <= s2_reg.gen_end ? '0 : live_next;
        end
    end

    lgs_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (bundle),
        .level       (q_level),
        .result_chan (result_chan)
    );

`ifndef SYNTH
    // Every accepted cell reaches the rule stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s2_valid_reg)
        else $error("accepted cell missing from rule stage");

    // Generation end has already returned the raster position to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_reg.gen_end) |-> (col_reg == '0 && row_reg == '0))
        else $error("raster position not cleared at generation end");

    // Live count never passes its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_LIMIT)
        else $error("live count beyond limit");
`endif

endmodule

/* sv/lgs_result_queue.sv */
// Result queue: holds per-cell result bundles and sends them one result per transfer.
module lgs_result_queue
    import lgs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bundle_t              push_bundle,
    output logic [Q_LVL_W-1:0]   level,
    lgs_result_if.source         result_chan
);

    bundle_t              entry_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_LVL_W-1:0]   level_reg;
    logic [Q_LVL_W-1:0]   level_next;
    logic [SLOT_W-1:0]    sub_reg;
    bundle_t              head;
    result_t              head_res;
    logic                 out_xfer;
    logic                 last_slot;
    logic                 pop;

    // Select the pending result at the head
    assign head      = entry_mem[rd_ptr_reg];
    assign head_res  = head.res[sub_reg];
    assign out_xfer  = result_chan.valid && result_chan.ready;
    assign last_slot = (sub_reg == head.count - SLOT_W'(1));
    assign pop       = out_xfer && last_slot;

    assign level_next = level_reg + Q_LVL_W'(push) - Q_LVL_W'(pop);
    assign level      = level_reg;

    // Drive the result channel
    assign result_chan.valid           = (level_reg != '0);
    assign result_chan.cell_column     = head_res.column;
    assign result_chan.cell_row        = head_res.row;
    assign result_chan.next_alive      = head_res.alive;
    assign result_chan.live_total      = head_res.live;
    assign result_chan.generation_done = head_res.done;

    // Store incoming bundles
    always_ff @(posedge clk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_bundle;
        end
    end

    // Advance pointers, fill level and slot index
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            level_reg <= level_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
                sub_reg    <= '0;
            end else if (out_xfer) begin
                sub_reg <= sub_reg + SLOT_W'(1);
            end
        end
    end

`ifndef SYNTH
    // No bundle arrives while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg < Q_LVL_W'(Q_DEPTH)))
        else $error("result queue overflow");

    // Only non-empty bundles are queued
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_bundle.count != '0))
        else $error("empty bundle pushed");

    // The slot index stays within the head bundle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid |-> (sub_reg < head.count))
        else $error("slot index beyond head bundle");
`endif

endmodule

/* tb/sv/life_generation_stencil_test.sv */
// Self-checking testbench for the Life generation stencil: reset size shrink, rule cases, size extremes, random grids.
module life_generation_stencil_test;
    import lgs_pkg::*;

    localparam int STUCK_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_CELLS  = 16;
    localparam int EXTREME_CELLS = 24;
    localparam int REPORT_CAP    = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    lgs_cell_if   cell_chan();
    lgs_result_if result_chan();

    life_generation_stencil uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cell_chan   (cell_chan),
        .result_chan (result_chan)
    );

    // Predicted block state
    logic [DIM_W-1:0]  width_reg  = DIM_W'(RESET_DIM);
    logic [DIM_W-1:0]  height_reg = DIM_W'(RESET_DIM);
    bit                above_row [MAX_WIDTH];
    bit                middle_row [MAX_WIDTH];
    logic [8:0]        window = '0;
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    logic [LIVE_W-1:0] live_count = '0;

    result_t     next_cells_due [$];
    result_t     seen_cell;
    result_t     due_cell;
    int unsigned cells_sent = 0;
    int unsigned fail_count = 0;
    int unsigned stuck_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic int unsigned clamp_to_grid(input logic [DIM_W-1:0] v,
                                                  input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void queue_next_cell(input int unsigned col, input int unsigned row,
                                            input bit alive, input bit done);
        result_t r;
        r.column = COORD_W'(col);
        r.row    = COORD_W'(row);
        r.alive  = alive;
        r.live   = live_count;
        r.done   = done;
        next_cells_due.push_back(r);
    endfunction

    // Shift one cell into the window and queue the next-generation cells it releases
    function automatic void advance_life_window(input bit cell_value);
        int unsigned w, h, x, y, nbrs;
        bit up, mid, center, alive, row_end, last_row, gen_end;
        w = clamp_to_grid(width_reg, MAX_WIDTH);
        h = clamp_to_grid(height_reg, MAX_HEIGHT);
        x = col_pos;
        y = row_pos;
        row_end  = (x >= w - 1);
        last_row = (y >= h - 1) && (y >= 1);
        gen_end  = row_end && last_row;

        up  = above_row[x];
        mid = middle_row[x];
        above_row[x]  = mid;
        middle_row[x] = cell_value;
        window = {cell_value, mid, up, window[8:3]};

        if (y == 0) begin
            queue_next_cell(x, 0, 1'b0, 1'b0);
        end else if (y >= 2) begin
            if (x == 1) begin
                queue_next_cell(0, y - 1, 1'b0, 1'b0);
            end else if (x >= 2) begin
                center = window[4];
                nbrs   = $countones(window) - center;
                alive  = (nbrs == BIRTH_COUNT) || (nbrs == SURVIVE_COUNT && center);
                if (alive && live_count < LIVE_LIMIT)
                    live_count++;
                queue_next_cell(x - 1, y - 1, alive, 1'b0);
            end
            // dead right edge of the row above
            if (row_end && x >= 1)
                queue_next_cell(x, y - 1, 1'b0, 1'b0);
        end
        if (last_row)
            queue_next_cell(x, y, 1'b0, gen_end);

        if (gen_end) begin
            col_pos    = 0;
            row_pos    = 0;
            live_count = '0;
            window     = '0;
        end else if (row_end) begin
            col_pos = 0;
            row_pos = y + 1;
        end else begin
            col_pos = x + 1;
        end
    endfunction

    // Offer one cell, with random idle cycles ahead of it, and hold until transfer
    task automatic send_cell(input bit alive);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_chan.valid = 1'b0;
            @(negedge clk);
        end
        cell_chan.valid   = 1'b1;
        cell_chan.cell_in = alive;
        @(posedge clk);
        while (!cell_chan.ready)
            @(posedge clk);
        advance_life_window(alive);
        cells_sent++;
        @(negedge clk);
    endtask

    // Drop valid, drain all expected results, then let the pipeline settle
    task automatic wait_quiet();
        cell_chan.valid = 1'b0;
        while (next_cells_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_GRID_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    // Send cells until the generation closes; optionally shrink the grid partway through
    task automatic run_generation(input int unsigned density, input bit cut_short);
        int unsigned w, h, n;
        int cut_at;
        w = clamp_to_grid(width_reg, MAX_WIDTH);
        h = clamp_to_grid(height_reg, MAX_HEIGHT);
        cut_at = cut_short ? int'($urandom_range(1, w * h - 1)) : -1;
        n = 0;
        do
        begin
            if (n == cut_at) begin
                wait_quiet();
                if ($urandom_range(1))
                    write_dim(CFG_GRID_WIDTH, DIM_W'($urandom_range(MIN_DIM, w)));
                else
                    write_dim(CFG_GRID_HEIGHT, DIM_W'($urandom_range(MIN_DIM, h)));
            end
            send_cell($urandom_range(99) < density);
            n++;
        end
        while (col_pos != 0 || row_pos != 0);
    endtask

    // Start at reset size, shrink both sizes mid-row below range, finish all alive
    task automatic test_reset_size_shrink();
        repeat (4) send_cell(1'b1);
        wait_quiet();
        write_dim(CFG_GRID_WIDTH, DIM_W'(2));
        write_dim(CFG_GRID_HEIGHT, DIM_W'(0));
        run_generation(100, 1'b0);
    endtask

    // Birth on three neighbors, survival on two, on the smallest grid
    task automatic test_rule_cases();
        logic [8:0] pattern [2] = '{9'b111_000_000, 9'b101_010_000};
        wait_quiet();
        write_dim(CFG_GRID_WIDTH, DIM_W'(3));
        write_dim(CFG_GRID_HEIGHT, DIM_W'(3));
        foreach (pattern[i])
            for (int b = 8; b >= 0; b--)
                send_cell(pattern[i][b]);
    endtask

    // Widest grid and tallest grid, both written above range, each closed early by a shrink
    task automatic test_dimension_extremes();
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        wait_quiet();
        write_dim(CFG_GRID_WIDTH, DIM_W'(1025));
        write_dim(CFG_GRID_HEIGHT, DIM_W'(3));
        repeat (EXTREME_CELLS) send_cell($urandom_range(1) != 0);
        wait_quiet();
        write_dim(CFG_GRID_WIDTH, DIM_W'(3));
        run_generation($urandom_range(100), 1'b0);
        wait_quiet();
        write_dim(CFG_GRID_HEIGHT, DIM_W'(2047));
        repeat (EXTREME_CELLS) send_cell($urandom_range(1) != 0);
        wait_quiet();
        write_dim(CFG_GRID_HEIGHT, DIM_W'(3));
        run_generation($urandom_range(100), 1'b0);
    endtask

    // Whole generations of random size and density under one idling mix
    task automatic test_random_grids(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned start, w, h;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = cells_sent;
        while (cells_sent - start < RANDOM_CELLS) begin
            case ($urandom_range(9))
                0:       w = $urandom_range(2);
                1:       w = $urandom_range(9, 20);
                default: w = $urandom_range(3, 8);
            endcase
            case ($urandom_range(9))
                0:       h = $urandom_range(2);
                1:       h = $urandom_range(7, 12);
                default: h = $urandom_range(3, 6);
            endcase
            wait_quiet();
            write_dim(CFG_GRID_WIDTH, DIM_W'(w));
            write_dim(CFG_GRID_HEIGHT, DIM_W'(h));
            run_generation($urandom_range(100), $urandom_range(7) == 0);
        end
    endtask

    // Receiver: stall at random on the falling edge
    always @(negedge clk)
        result_chan.ready = ($urandom_range(99) >= recv_stall_pct);

    // Compare each result transfer with the oldest expected cell
    always @(posedge clk)
    begin
        if (rst_n && result_chan.valid && result_chan.ready) begin
            seen_cell.column = result_chan.cell_column;
            seen_cell.row    = result_chan.cell_row;
            seen_cell.alive  = result_chan.next_alive;
            seen_cell.live   = result_chan.live_total;
            seen_cell.done   = result_chan.generation_done;
            if (next_cells_due.size() == 0) begin
                report_mismatch("unexpected result at column", seen_cell.column, -1);
            end else begin
                due_cell = next_cells_due.pop_front();
                if (seen_cell.column !== due_cell.column)
                    report_mismatch("cell_column", seen_cell.column, due_cell.column);
                if (seen_cell.row !== due_cell.row)
                    report_mismatch("cell_row", seen_cell.row, due_cell.row);
                if (seen_cell.alive !== due_cell.alive)
                    report_mismatch("next_alive", seen_cell.alive, due_cell.alive);
                if (seen_cell.live !== due_cell.live)
                    report_mismatch("live_total", seen_cell.live, due_cell.live);
                if (seen_cell.done !== due_cell.done)
                    report_mismatch("generation_done", seen_cell.done, due_cell.done);
            end
        end
    end

    // Watchdog: count cycles with work outstanding and no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (cell_chan.valid && cell_chan.ready)
                || (result_chan.valid && result_chan.ready)
                || (next_cells_due.size() == 0 && !cell_chan.valid)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_GRID_WIDTH;
        cfg_data          = '0;
        cell_chan.valid   = 1'b0;
        cell_chan.cell_in = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_size_shrink();
        test_rule_cases();
        test_dimension_extremes();
        test_random_grids(0, 0);
        test_random_grids(61, 0);
        test_random_grids(0, 61);
        test_random_grids(13, 13);
        wait_quiet();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
